// ===== sv/flt_pkg.sv =====
// Shared constants and control types for the fraction reducer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package flt_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DATA_WIDTH);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]      count_type;

   localparam data_type MAX_POS  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type ONE      = DATA_WIDTH'(1);
   localparam data_type ZERO     = '0;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
   } status_type;

endpackage

// ===== sv/flt_req_if.sv =====
// Request channel: signed numerator and denominator with valid/ready.
// Depends on flt_pkg for the data width.
interface flt_req_if;
   logic               valid;
   logic               ready;
   flt_pkg::data_type  numerator_in;
   flt_pkg::data_type  denominator_in;

   modport source (output valid, numerator_in, denominator_in, input ready);
   modport sink   (input valid, numerator_in, denominator_in, output ready);
endinterface

// ===== sv/flt_rsp_if.sv =====
// Response channel: reduced fraction and zero-denominator flag with valid/ready.
// Depends on flt_pkg for the data width.
interface flt_rsp_if;
   logic               valid;
   logic               ready;
   flt_pkg::data_type  numerator_out;
   flt_pkg::data_type  denominator_out;
   logic               zero_denominator;

   modport source (output valid, numerator_out, denominator_out, zero_denominator,
                   input ready);
   modport sink   (input valid, numerator_out, denominator_out, zero_denominator,
                   output ready);
endinterface

// ===== sv/flt_datapath.sv =====
// Datapath: binary GCD on the magnitudes, two restoring dividers, output formatting.
// Driven by flt_ctrl through flt_pkg::cmd_type; reports flt_pkg::status_type.
module flt_datapath (
   input  logic                 clock,
   input  flt_pkg::cmd_type     cmd,
   output flt_pkg::status_type  status,
   input  flt_pkg::data_type    req_numerator,
   input  flt_pkg::data_type    req_denominator,
   output flt_pkg::data_type    rsp_numerator,
   output flt_pkg::data_type    rsp_denominator,
   output logic                 rsp_zero_denominator
);

   localparam int W = flt_pkg::DATA_WIDTH;

   function automatic flt_pkg::data_type mag(input flt_pkg::data_type v);
      mag = v[W-1] ? (~v + 1'b1) : v;
   endfunction

   flt_pkg::data_type num_raw_ff, den_raw_ff;
   flt_pkg::data_type a_ff, a_in, b_ff, b_in;
   flt_pkg::data_type nq_ff, nq_in, dq_ff, dq_in;
   flt_pkg::data_type nrem_ff, nrem_in, drem_ff, drem_in;
   logic              neg_ff, zden_ff, znum_ff;
   flt_pkg::data_type out_num_ff, out_den_ff;
   logic              out_zd_ff;

   flt_pkg::data_type n_trial, d_trial, fmt_num, fmt_den;
   logic              n_fit, d_fit;

   assign n_trial = {nrem_ff[W-2:0], nq_ff[W-1]};
   assign d_trial = {drem_ff[W-2:0], dq_ff[W-1]};
   assign n_fit   = n_trial >= a_ff;
   assign d_fit   = d_trial >= a_ff;

   assign status.special  = zden_ff | znum_ff;
   assign status.gcd_done = a_ff == b_ff;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      nq_in   = nq_ff;
      dq_in   = dq_ff;
      nrem_in = nrem_ff;
      drem_in = drem_ff;
      if (cmd.load) begin
         a_in  = mag(req_numerator);
         b_in  = mag(req_denominator);
         nq_in = mag(req_numerator);
         dq_in = mag(req_denominator);
      end else if (cmd.gcd_step) begin
         priority if (!a_ff[0] && !b_ff[0]) begin
            a_in  = a_ff >> 1;
            b_in  = b_ff >> 1;
            nq_in = nq_ff >> 1;
            dq_in = dq_ff >> 1;
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end else if (cmd.div_init) begin
         nrem_in = flt_pkg::ZERO;
         drem_in = flt_pkg::ZERO;
      end else if (cmd.div_step) begin
         nrem_in = n_fit ? (n_trial - a_ff) : n_trial;
         drem_in = d_fit ? (d_trial - a_ff) : d_trial;
         nq_in   = {nq_ff[W-2:0], n_fit};
         dq_in   = {dq_ff[W-2:0], d_fit};
      end
   end

   always_comb begin
      priority if (zden_ff) begin
         fmt_num = num_raw_ff;
         fmt_den = den_raw_ff;
      end else if (znum_ff) begin
         fmt_num = flt_pkg::ZERO;
         fmt_den = flt_pkg::ONE;
      end else begin
         fmt_den = dq_ff[W-1] ? flt_pkg::MAX_POS : dq_ff;
         if (neg_ff) begin
            fmt_num = ~nq_ff + 1'b1;
         end else begin
            fmt_num = nq_ff[W-1] ? flt_pkg::MAX_POS : nq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      nq_ff   <= nq_in;
      dq_ff   <= dq_in;
      nrem_ff <= nrem_in;
      drem_ff <= drem_in;
      if (cmd.load) begin
         num_raw_ff <= req_numerator;
         den_raw_ff <= req_denominator;
         neg_ff     <= req_numerator[W-1] ^ req_denominator[W-1];
         zden_ff    <= req_denominator == flt_pkg::ZERO;
         znum_ff    <= req_numerator == flt_pkg::ZERO;
      end
      if (cmd.out_load) begin
         out_num_ff <= fmt_num;
         out_den_ff <= fmt_den;
         out_zd_ff  <= zden_ff;
      end
   end

   assign rsp_numerator        = out_num_ff;
   assign rsp_denominator      = out_den_ff;
   assign rsp_zero_denominator = out_zd_ff;

endmodule

// ===== sv/flt_ctrl.sv =====
// Controller: sequences load, GCD steps, division steps and the result register.
// Depends on flt_pkg for command and status types.
module flt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output flt_pkg::cmd_type     cmd,
   input  flt_pkg::status_type  status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GCD  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   localparam flt_pkg::count_type CNT_LAST = flt_pkg::CNT_W'(flt_pkg::DATA_WIDTH - 1);

   logic [1:0]          state_ff, state_in;
   flt_pkg::count_type  cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            priority if (status.special) begin
               state_in = ST_FIN;
            end else if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while pending");

   a_load_to_gcd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_GCD))
      else $error("accepted request did not start GCD");

   a_special_skip: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD && status.special) |=> (state_ff == ST_FIN))
      else $error("special case did not bypass arithmetic");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == CNT_LAST) |=> (state_ff == ST_FIN))
      else $error("division did not finish after full width");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.gcd_step, cmd.div_init, cmd.div_step, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

// ===== sv/fraction_lowest_terms.sv =====
// Sequence: request load, binary GCD steps, restoring division steps, then the response
// register; a zero numerator or denominator skips the GCD and division steps.
// Throughput: one request at a time, set by the shared GCD/divider datapath.
// The response register lets the next request start while a result waits.
// Reset is synchronous, active high; it clears the controller and the response valid.
module fraction_lowest_terms (
   input  logic     clock,
   input  logic     reset,
   flt_req_if.sink  req_if,
   flt_rsp_if.source rsp_if
);

   flt_pkg::cmd_type     cmd;
   flt_pkg::status_type  status;

   flt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   flt_datapath u_datapath (
      .clock                (clock),
      .cmd                  (cmd),
      .status               (status),
      .req_numerator        (req_if.numerator_in),
      .req_denominator      (req_if.denominator_in),
      .rsp_numerator        (rsp_if.numerator_out),
      .rsp_denominator      (rsp_if.denominator_out),
      .rsp_zero_denominator (rsp_if.zero_denominator)
   );

endmodule
